/* rtl/mwfpm_pkg.sv */
// ----------------------------------------------------------------------------
// Multiword fixed-point multiplier package
// Sizes, the sequencer state type and the structs shared by the modules.
// ----------------------------------------------------------------------------
package mwfpm_pkg;

   localparam int WORDS      = 4;                   // words per operand, 1..8
   localparam int WORD_W     = 32;
   localparam int EIW_W      = 2;                   // extra integer word field
   localparam int IDX_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W      = $clog2(WORDS + 1);
   localparam int PROD_DEPTH = 2 * WORDS;
   localparam int COL_W      = $clog2(PROD_DEPTH);
   localparam int SRC_W      = COL_W + 1;
   localparam int ACC_W      = 2 * WORD_W + IDX_W + 1;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_NEG  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // one word pair issued to the multiply-accumulate pipe
   typedef struct packed {
      logic             valid;
      logic             col_end;   // last pair of this product column
      logic             zero;      // carry flush, no real pair
      logic [COL_W-1:0] col;
   } mac_tag_type;

   // write into the product memory
   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } prod_wr_type;

endpackage

/* rtl/mwfpm_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one word pair of the two operands.
// ----------------------------------------------------------------------------
interface mwfpm_req_if;

   logic                      valid;
   logic                      ready;
   logic [mwfpm_pkg::WORD_W-1:0] a_word;
   logic [mwfpm_pkg::WORD_W-1:0] b_word;

   modport source (output valid, output a_word, output b_word, input ready);
   modport sink   (input valid, input a_word, input b_word, output ready);

endinterface

/* rtl/mwfpm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one product word and its last marker.
// ----------------------------------------------------------------------------
interface mwfpm_rsp_if;

   logic                      valid;
   logic                      ready;
   logic [mwfpm_pkg::WORD_W-1:0] result_word;
   logic                      last_word;

   modport source (output valid, output result_word, output last_word, input ready);
   modport sink   (input valid, input result_word, input last_word, output ready);

endinterface

/* rtl/mwfpm_col_mac.sv */
// ----------------------------------------------------------------------------
// Column multiply-accumulate
// Multiplies word pairs and sums each product column into a wide
// accumulator; at a column end the low word is written out and the rest
// carries into the next column.
// ----------------------------------------------------------------------------
module mwfpm_col_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  mwfpm_pkg::mac_tag_type       tag,
   input  logic [mwfpm_pkg::WORD_W-1:0] a_rd,
   input  logic [mwfpm_pkg::WORD_W-1:0] b_rd,
   output mwfpm_pkg::prod_wr_type       prod_wr,
   output logic                         busy
);

   mwfpm_pkg::mac_tag_type                 s1_tag_ff;
   mwfpm_pkg::mac_tag_type                 s2_tag_ff;
   logic [2*mwfpm_pkg::WORD_W-1:0]         mult;
   logic [2*mwfpm_pkg::WORD_W-1:0]         prod_ff;
   logic [2*mwfpm_pkg::WORD_W-1:0]         prod_in;
   logic [mwfpm_pkg::ACC_W-1:0]            acc_ff;
   logic [mwfpm_pkg::ACC_W-1:0]            acc_in;
   logic [mwfpm_pkg::ACC_W-1:0]            sum;

   // read data arrives in the cycle after the tag
   assign mult    = a_rd * b_rd;
   assign prod_in = s1_tag_ff.zero ? '0 : mult;

   assign sum = acc_ff + mwfpm_pkg::ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (s2_tag_ff.valid) begin
         acc_in = s2_tag_ff.col_end ? (sum >> mwfpm_pkg::WORD_W) : sum;
      end
   end

   assign prod_wr.en   = s2_tag_ff.valid && s2_tag_ff.col_end;
   assign prod_wr.addr = s2_tag_ff.col;
   assign prod_wr.data = sum[mwfpm_pkg::WORD_W-1:0];

   assign busy = s1_tag_ff.valid || s2_tag_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // a column end always follows its pairs in issue order
   assert property (@(posedge clock) disable iff (reset)
      (s2_tag_ff.valid && s2_tag_ff.col_end && s1_tag_ff.valid)
      |-> (s1_tag_ff.col != s2_tag_ff.col))
      else $error("mwfpm_col_mac: pair issued after its column closed");

   assert property (@(posedge clock) disable iff (reset)
      s1_tag_ff.zero && s1_tag_ff.valid |-> s1_tag_ff.col_end)
      else $error("mwfpm_col_mac: carry flush not at column end");

   assert property (@(posedge clock) disable iff (reset)
      clear |-> !busy)
      else $error("mwfpm_col_mac: accumulator cleared while busy");

endmodule

/* rtl/multiword_fixed_point_multiplier_top.sv */
// ----------------------------------------------------------------------------
// Multiword fixed-point multiplier, top level
// Per product: WORDS request transfers load the operands, a sign pass
//   takes the two's complement of negative operands, WORDS^2 + 1 steps of
//   the one shared 32x32 multiplier and a pipe drain fill the product
//   memory, and WORDS response words are read out through the product
//   read and response registers. A new product is accepted only after the
//   last response word of the previous one is loaded for the response.
// Reset: synchronous, returns the sequencer to ST_LOAD and clears the load
//   count, config register and valid flags; operand and product memories keep their contents.
// ----------------------------------------------------------------------------
module multiword_fixed_point_multiplier_top (
   input  logic                        clock,
   input  logic                        reset,
   mwfpm_req_if.sink                   req_ch,
   mwfpm_rsp_if.source                 rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [mwfpm_pkg::EIW_W-1:0] csr_wr_data
);

   localparam int W = mwfpm_pkg::WORDS;
   localparam int DW = mwfpm_pkg::WORD_W;
   localparam int IW = mwfpm_pkg::IDX_W;
   localparam int CW = mwfpm_pkg::CNT_W;
   localparam int KW = mwfpm_pkg::COL_W;
   localparam int SW = mwfpm_pkg::SRC_W;

   // --- state -----------------------------------------------------------
   mwfpm_pkg::state_type state_ff, state_in;

   logic [mwfpm_pkg::EIW_W-1:0] eiw_ff, eiw_in;     // config register
   logic [mwfpm_pkg::EIW_W-1:0] op_eiw_ff, op_eiw_in; // value for this product
   logic [IW-1:0] load_cnt_ff, load_cnt_in;

   logic a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic a_carry_ff, a_carry_in, b_carry_ff, b_carry_in;

   // sign pass: read, then write back the two's complement
   logic [CW-1:0] neg_n_ff, neg_n_in;
   logic          neg_v_ff, neg_v_in;
   logic [IW-1:0] neg_wa_ff, neg_wa_in;

   // column sequencer
   logic [KW-1:0] mul_k_ff, mul_k_in;
   logic [IW-1:0] mul_i_ff, mul_i_in;
   logic          mul_done_ff, mul_done_in;

   // response side
   logic [CW-1:0] out_k_ff, out_k_in;
   logic          pend_ff, pend_in;          // product read data waiting
   logic          pend_zero_ff, pend_zero_in;
   logic          pend_last_ff, pend_last_in;
   logic          res_carry_ff, res_carry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_word_ff, rsp_word_in;
   logic          rsp_last_ff, rsp_last_in;

   // --- memories --------------------------------------------------------
   logic [DW-1:0] a_mem [W];
   logic [DW-1:0] b_mem [W];
   logic [DW-1:0] prod_mem [mwfpm_pkg::PROD_DEPTH];
   logic [DW-1:0] a_rd_ff, b_rd_ff, prod_rd_ff;

   logic          ab_we;
   logic [IW-1:0] ab_wa;
   logic [DW-1:0] a_wd, b_wd;
   logic [IW-1:0] a_ra, b_ra;
   logic          prod_re;
   logic [KW-1:0] prod_ra;

   mwfpm_pkg::mac_tag_type mac_tag;
   mwfpm_pkg::prod_wr_type prod_wr;
   logic                   mac_busy;
   logic                   mac_clear;

   // --- combinational helpers -------------------------------------------
   logic          req_xfer;
   logic          load_last;
   logic [DW-1:0] a_fix, b_fix;
   logic [DW:0]   a_sum, b_sum;

   logic [IW-1:0] i_hi, i_lo_next, mul_j;
   logic [KW-1:0] k_next;
   logic          col_dummy, col_end, mul_issue;

   logic [SW-1:0] src_base, src;
   logic          src_low, src_out;
   logic          out_load, out_issue;
   logic [DW-1:0] res_raw, res_fix;
   logic [DW:0]   res_sum;
   logic          res_neg;

   assign req_ch.ready = (state_ff == mwfpm_pkg::ST_LOAD);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign load_last    = (load_cnt_ff == IW'(W - 1));

   // two's complement of a stored word, carry rippling up one word a cycle
   assign a_fix = a_neg_ff ? ~a_rd_ff : a_rd_ff;
   assign b_fix = b_neg_ff ? ~b_rd_ff : b_rd_ff;
   assign a_sum = {1'b0, a_fix} + (DW + 1)'(a_carry_ff);
   assign b_sum = {1'b0, b_fix} + (DW + 1)'(b_carry_ff);

   // Product scanning: column k takes pairs (i, k-i) with i running
   // max(0, k-W+1) .. min(k, W-1). One extra flush step after the last
   // column writes the top carry word.
   assign i_hi      = (mul_k_ff < KW'(W)) ? mul_k_ff[IW-1:0] : IW'(W - 1);
   assign k_next    = mul_k_ff + KW'(1);
   assign i_lo_next = (k_next >= KW'(W)) ? IW'(k_next - KW'(W - 1)) : '0;
   assign mul_j     = IW'(mul_k_ff - KW'(mul_i_ff));
   assign col_dummy = (mul_k_ff == KW'(2 * W - 1));
   assign col_end   = col_dummy || (mul_i_ff == i_hi);
   assign mul_issue = (state_ff == mwfpm_pkg::ST_MUL) && !mul_done_ff;

   assign mac_tag.valid   = mul_issue;
   assign mac_tag.col_end = col_end;
   assign mac_tag.zero    = col_dummy;
   assign mac_tag.col     = mul_k_ff;

   // window at the fraction offset: source word = k + W-1 - eiw
   assign src_base = SW'(out_k_ff) + SW'(W - 1);
   assign src_low  = (src_base < SW'(op_eiw_ff));
   assign src      = src_base - SW'(op_eiw_ff);
   assign src_out  = src_low || (src >= SW'(mwfpm_pkg::PROD_DEPTH));

   assign res_neg   = a_neg_ff ^ b_neg_ff;
   assign out_load  = pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign out_issue = (state_ff == mwfpm_pkg::ST_OUT) && (out_k_ff < CW'(W))
                      && (!pend_ff || out_load);

   assign res_raw = pend_zero_ff ? '0 : prod_rd_ff;
   assign res_fix = res_neg ? ~res_raw : res_raw;
   assign res_sum = {1'b0, res_fix} + (DW + 1)'(res_carry_ff);

   // --- memory ports ----------------------------------------------------
   // Sign-pass write-backs never overlap request transfers (different states),
   // and the next pass starts only after the last write-back landed.
   assign ab_we = req_xfer || neg_v_ff;
   assign ab_wa = neg_v_ff ? neg_wa_ff : load_cnt_ff;
   assign a_wd  = neg_v_ff ? a_sum[DW-1:0] : req_ch.a_word;
   assign b_wd  = neg_v_ff ? b_sum[DW-1:0] : req_ch.b_word;

   assign a_ra = (state_ff == mwfpm_pkg::ST_NEG) ? neg_n_ff[IW-1:0] : mul_i_ff;
   assign b_ra = (state_ff == mwfpm_pkg::ST_NEG) ? neg_n_ff[IW-1:0] : mul_j;

   assign prod_re = out_issue;
   assign prod_ra = src[KW-1:0];

   always_ff @(posedge clock) begin
      if (ab_we) begin
         a_mem[ab_wa] <= a_wd;
         b_mem[ab_wa] <= b_wd;
      end
      a_rd_ff <= a_mem[a_ra];
      b_rd_ff <= b_mem[b_ra];
   end

   // read data holds while the response register is stalled
   always_ff @(posedge clock) begin
      if (prod_wr.en) begin
         prod_mem[prod_wr.addr] <= prod_wr.data;
      end
      if (prod_re) begin
         prod_rd_ff <= prod_mem[prod_ra];
      end
   end

   assign mac_clear = (state_ff == mwfpm_pkg::ST_NEG);

   mwfpm_col_mac u_col_mac (
      .clock   (clock),
      .reset   (reset),
      .clear   (mac_clear),
      .tag     (mac_tag),
      .a_rd    (a_rd_ff),
      .b_rd    (b_rd_ff),
      .prod_wr (prod_wr),
      .busy    (mac_busy)
   );

   // --- sequencer ---------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      eiw_in       = csr_wr_en ? csr_wr_data : eiw_ff;
      op_eiw_in    = op_eiw_ff;
      load_cnt_in  = load_cnt_ff;
      a_neg_in     = a_neg_ff;
      b_neg_in     = b_neg_ff;
      a_carry_in   = a_carry_ff;
      b_carry_in   = b_carry_ff;
      neg_n_in     = neg_n_ff;
      neg_v_in     = 1'b0;
      neg_wa_in    = neg_n_ff[IW-1:0];
      mul_k_in     = mul_k_ff;
      mul_i_in     = mul_i_ff;
      mul_done_in  = mul_done_ff;
      out_k_in     = out_k_ff;
      pend_in      = pend_ff;
      pend_zero_in = pend_zero_ff;
      pend_last_in = pend_last_ff;
      res_carry_in = res_carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         mwfpm_pkg::ST_LOAD: begin
            if (req_xfer) begin
               if (load_last) begin
                  // top word carries the signs
                  load_cnt_in = '0;
                  a_neg_in    = req_ch.a_word[DW-1];
                  b_neg_in    = req_ch.b_word[DW-1];
                  a_carry_in  = req_ch.a_word[DW-1];
                  b_carry_in  = req_ch.b_word[DW-1];
                  op_eiw_in   = eiw_in;
                  neg_n_in    = '0;
                  state_in    = mwfpm_pkg::ST_NEG;
               end else begin
                  load_cnt_in = load_cnt_ff + IW'(1);
               end
            end
         end
         mwfpm_pkg::ST_NEG: begin
            if (neg_n_ff < CW'(W)) begin
               neg_v_in = 1'b1;
               neg_n_in = neg_n_ff + CW'(1);
            end else if (!neg_v_ff) begin
               mul_k_in    = '0;
               mul_i_in    = '0;
               mul_done_in = 1'b0;
               state_in    = mwfpm_pkg::ST_MUL;
            end
            if (neg_v_ff) begin
               a_carry_in = a_sum[DW];
               b_carry_in = b_sum[DW];
            end
         end
         mwfpm_pkg::ST_MUL: begin
            if (mul_issue) begin
               if (col_dummy) begin
                  mul_done_in = 1'b1;
               end else if (col_end) begin
                  mul_k_in = k_next;
                  mul_i_in = i_lo_next;
               end else begin
                  mul_i_in = mul_i_ff + IW'(1);
               end
            end else if (!mac_busy) begin
               out_k_in     = '0;
               pend_in      = 1'b0;
               res_carry_in = res_neg;
               state_in     = mwfpm_pkg::ST_OUT;
            end
         end
         mwfpm_pkg::ST_OUT: begin
            if (out_issue) begin
               pend_in      = 1'b1;
               pend_zero_in = src_out;
               pend_last_in = (out_k_ff == CW'(W - 1));
               out_k_in     = out_k_ff + CW'(1);
            end else if (out_load) begin
               pend_in = 1'b0;
            end
            if (out_load && pend_last_ff) begin
               state_in = mwfpm_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mwfpm_pkg::ST_LOAD;
         end
      endcase

      // response register parts the response side from the sequencer
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_sum[DW-1:0];
         rsp_last_in  = pend_last_ff;
         res_carry_in = res_sum[DW];
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwfpm_pkg::ST_LOAD;
         eiw_ff       <= '0;
         load_cnt_ff  <= '0;
         neg_v_ff     <= 1'b0;
         mul_done_ff  <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eiw_ff       <= eiw_in;
         load_cnt_ff  <= load_cnt_in;
         neg_v_ff     <= neg_v_in;
         mul_done_ff  <= mul_done_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_eiw_ff    <= op_eiw_in;
      a_neg_ff     <= a_neg_in;
      b_neg_ff     <= b_neg_in;
      a_carry_ff   <= a_carry_in;
      b_carry_ff   <= b_carry_in;
      neg_n_ff     <= neg_n_in;
      neg_wa_ff    <= neg_wa_in;
      mul_k_ff     <= mul_k_in;
      mul_i_ff     <= mul_i_in;
      out_k_ff     <= out_k_in;
      pend_zero_ff <= pend_zero_in;
      pend_last_ff <= pend_last_in;
      res_carry_ff <= res_carry_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_word = rsp_word_ff;
   assign rsp_ch.last_word   = rsp_last_ff;

   // --- checks ------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      prod_wr.en |-> (state_ff == mwfpm_pkg::ST_MUL))
      else $error("product memory written outside the multiply phase");

   assert property (@(posedge clock) disable iff (reset)
      neg_v_ff |-> !req_xfer)
      else $error("sign write-back collides with a request transfer");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == mwfpm_pkg::ST_OUT))
      else $error("product read pending outside the response phase");

   assert property (@(posedge clock) disable iff (reset)
      (out_load && pend_last_ff) |=> (state_ff == mwfpm_pkg::ST_LOAD) && !pend_ff)
      else $error("sequencer did not return to load after the last word");

endmodule
